// ===== rtl/mbsd_pkg.sv =====
// Shared types, constants and formatting functions for the multi-buffer segment display.
`default_nettype none

package mbsd_pkg;

   // Default number of virtual buffers.
   localparam int MaxBuffers = 8;

   localparam int CountWidth  = 4;
   localparam int IndexWidth  = 8;
   localparam int SegWidth    = 32;
   localparam int HourWidth   = 7;
   localparam int TenthsWidth = 10;
   localparam int PctWidth    = 8;

   localparam logic [CountWidth-1:0] CountReset = 4'd1;

   localparam logic [7:0] SegColon  = 8'h80;
   localparam logic [7:0] SegDegree = 8'b0110_0011;
   localparam logic [7:0] SegH      = 8'b0111_0110;
   localparam logic [7:0] SegLowerO = 8'b0101_1100;

   localparam logic [HourWidth-1:0]   TwoDigitMax = 7'd99;
   localparam logic [TenthsWidth-1:0] TenthsMax   = 10'd999;

   typedef enum logic [2:0] {
      ACT_RAW     = 3'd0,
      ACT_TIME    = 3'd1,
      ACT_TEMP    = 3'd2,
      ACT_PERCENT = 3'd3,
      ACT_SELECT  = 3'd4,
      ACT_NEXT    = 3'd5
   } action_type;

   typedef enum logic [1:0] {
      CMD_NOP,
      CMD_WRITE,
      CMD_SELECT,
      CMD_NEXT
   } cmd_kind_type;

   // One classified command between the front and the back.
   typedef struct packed {
      cmd_kind_type            kind;
      logic [IndexWidth-1:0]   idx;
      logic [SegWidth-1:0]     data;
   } cmd_type;

   typedef struct packed {
      logic                    status;
      logic                    refresh;
      logic [SegWidth-1:0]     segments;
   } result_type;

   typedef struct packed {
      logic [3:0] tens;
      logic [3:0] units;
   } digits_type;

   function automatic logic [7:0] glyph(input logic [3:0] d);
      logic [7:0] g;
      case (d)
         4'd0: g = 8'h3f;
         4'd1: g = 8'h06;
         4'd2: g = 8'h5b;
         4'd3: g = 8'h4f;
         4'd4: g = 8'h66;
         4'd5: g = 8'h6d;
         4'd6: g = 8'h7d;
         4'd7: g = 8'h07;
         4'd8: g = 8'h7f;
         4'd9: g = 8'h6f;
         default: g = 8'h00;
      endcase
      return g;
   endfunction

   // Splits a value below 100 into decimal digits; x*205>>11 is x/10 in that range.
   function automatic digits_type div10(input logic [6:0] x);
      logic [14:0] prod;
      logic [3:0]  q;
      logic [6:0]  r;
      digits_type  res;
      prod = 15'(x) * 15'd205;
      q = prod[14:11];
      r = x - 7'(7'(q) * 7'd10);
      res.tens = q;
      res.units = r[3:0];
      return res;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/multi_buffer_segment_display.sv =====
// Top level of the multi-buffer seven-segment display controller.
//
//   channel   handshake          direction  word
//   request   push / full        in         action, buffer index, raw, time, temp, percent
//   response  pop / empty        out        status, refresh, segments
//   csr       csr_valid / ready  in         buffer count
//
// One item per cycle is sustained while the result queue has room; its result reaches
// the response ports after the front register, the command queue and the result queue.
// The front register stage formats the item, a two-entry queue feeds the back end, and
// the back end updates the buffers and pushes its result into a two-entry result queue.
// Synchronous reset clears all buffers, selects buffer 0 and sets the count to one.
// A full result queue stalls the back end, which in turn fills the command queue and
// raises full; csr_ready is always high.
`default_nettype none

module multi_buffer_segment_display #(
   parameter int MAX_BUFFERS = mbsd_pkg::MaxBuffers
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                push,
   output logic                                     full,
   input  wire logic [2:0]                          req_action,
   input  wire logic [mbsd_pkg::IndexWidth-1:0]     req_buffer_index,
   input  wire logic [mbsd_pkg::SegWidth-1:0]       req_raw_segments,
   input  wire logic [mbsd_pkg::HourWidth-1:0]      req_hour,
   input  wire logic [mbsd_pkg::HourWidth-1:0]      req_minute,
   input  wire logic [mbsd_pkg::TenthsWidth-1:0]    req_tenths_celsius,
   input  wire logic [mbsd_pkg::PctWidth-1:0]       req_percent,
   output logic                                     empty,
   input  wire logic                                pop,
   output logic                                     rsp_status,
   output logic                                     rsp_refresh,
   output logic [mbsd_pkg::SegWidth-1:0]            rsp_segments,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [mbsd_pkg::CountWidth-1:0]     csr_buffer_count
);

   mbsd_pkg::cmd_type      front_cmd, back_cmd;
   mbsd_pkg::result_type   back_res, out_res;
   logic                   front_valid, cmdq_ready;
   logic                   cmdq_valid, cmdq_pop;
   logic                   resq_ready, res_push, resq_valid;

   assign csr_ready    = 1'b1;
   assign empty        = !resq_valid;
   assign rsp_status   = out_res.status;
   assign rsp_refresh  = out_res.refresh;
   assign rsp_segments = out_res.segments;

   mbsd_front u_front (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .full               (full),
      .req_action         (req_action),
      .req_buffer_index   (req_buffer_index),
      .req_raw_segments   (req_raw_segments),
      .req_hour           (req_hour),
      .req_minute         (req_minute),
      .req_tenths_celsius (req_tenths_celsius),
      .req_percent        (req_percent),
      .cmd_valid          (front_valid),
      .cmd_ready          (cmdq_ready),
      .cmd                (front_cmd)
   );

   mbsd_fifo #(
      .WIDTH ($bits(mbsd_pkg::cmd_type))
   ) u_cmd_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (front_valid),
      .wr_ready (cmdq_ready),
      .wr_data  (front_cmd),
      .rd_valid (cmdq_valid),
      .rd_pop   (cmdq_pop),
      .rd_data  (back_cmd)
   );

   mbsd_back #(
      .MAX_BUFFERS (MAX_BUFFERS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid),
      .csr_data  (csr_buffer_count),
      .cmd_valid (cmdq_valid),
      .cmd_pop   (cmdq_pop),
      .cmd       (back_cmd),
      .res_ready (resq_ready),
      .res_push  (res_push),
      .res       (back_res)
   );

   mbsd_fifo #(
      .WIDTH ($bits(mbsd_pkg::result_type))
   ) u_res_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (res_push),
      .wr_ready (resq_ready),
      .wr_data  (back_res),
      .rd_valid (resq_valid),
      .rd_pop   (pop),
      .rd_data  (out_res)
   );

endmodule

`default_nettype wire

// ===== rtl/mbsd_fifo.sv =====
// Two-entry word queue used between the front and the back and on the result side.
`default_nettype none

module mbsd_fifo #(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_valid,
   output logic                  wr_ready,
   input  wire logic [WIDTH-1:0] wr_data,
   output logic                  rd_valid,
   input  wire logic             rd_pop,
   output logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_wr, do_rd;

   assign wr_ready = (count_ff != 2'd2);
   assign rd_valid = (count_ff != 2'd0);
   assign rd_data  = mem_ff[rd_ptr_ff];

   assign do_wr = wr_valid && wr_ready;
   assign do_rd = rd_pop && rd_valid;

   always_comb begin
      wr_ptr_in = do_wr ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_rd ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + 2'd1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/mbsd_front.sv =====
// Front end: accepts items, saturates and formats them into buffer commands.
`default_nettype none

module mbsd_front (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                push,
   output logic                                     full,
   input  wire logic [2:0]                          req_action,
   input  wire logic [mbsd_pkg::IndexWidth-1:0]     req_buffer_index,
   input  wire logic [mbsd_pkg::SegWidth-1:0]       req_raw_segments,
   input  wire logic [mbsd_pkg::HourWidth-1:0]      req_hour,
   input  wire logic [mbsd_pkg::HourWidth-1:0]      req_minute,
   input  wire logic [mbsd_pkg::TenthsWidth-1:0]    req_tenths_celsius,
   input  wire logic [mbsd_pkg::PctWidth-1:0]       req_percent,
   output logic                                     cmd_valid,
   input  wire logic                                cmd_ready,
   output mbsd_pkg::cmd_type                        cmd
);

   logic                                  valid_ff, valid_in;
   mbsd_pkg::action_type                  action_ff;
   logic [mbsd_pkg::IndexWidth-1:0]       idx_ff;
   logic [mbsd_pkg::SegWidth-1:0]         raw_ff;
   logic [mbsd_pkg::HourWidth-1:0]        hour_ff, hour_in;
   logic [mbsd_pkg::HourWidth-1:0]        minute_ff, minute_in;
   logic [3:0]                            hund_ff, hund_in;
   logic [6:0]                            trem_ff, trem_in;
   logic [mbsd_pkg::PctWidth-1:0]         pct_ff;

   logic [mbsd_pkg::TenthsWidth-1:0]      tenths_sat;
   logic [15:0]                           hund_prod;
   logic [mbsd_pkg::TenthsWidth-1:0]      trem_wide;
   logic                                  accept;

   mbsd_pkg::digits_type                  hour_d, minute_d, trem_d, pct_d;

   assign full      = valid_ff && !cmd_ready;
   assign accept    = push && !full;
   assign cmd_valid = valid_ff;

   // Saturation and the hundreds split of the temperature happen before the register.
   always_comb begin
      hour_in    = (req_hour > mbsd_pkg::TwoDigitMax) ? mbsd_pkg::TwoDigitMax : req_hour;
      minute_in  = (req_minute > mbsd_pkg::TwoDigitMax) ? mbsd_pkg::TwoDigitMax : req_minute;
      tenths_sat = (req_tenths_celsius > mbsd_pkg::TenthsMax) ?
                   mbsd_pkg::TenthsMax : req_tenths_celsius;
      hund_prod  = 16'(tenths_sat) * 16'd41;
      hund_in    = hund_prod[15:12];
      trem_wide  = tenths_sat - 10'(10'(hund_in) * 10'd100);
      trem_in    = trem_wide[6:0];
   end

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (valid_ff && cmd_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff <= mbsd_pkg::action_type'(req_action);
         idx_ff    <= req_buffer_index;
         raw_ff    <= req_raw_segments;
         hour_ff   <= hour_in;
         minute_ff <= minute_in;
         hund_ff   <= hund_in;
         trem_ff   <= trem_in;
         pct_ff    <= req_percent;
      end
   end

   always_comb begin
      hour_d   = mbsd_pkg::div10(hour_ff);
      minute_d = mbsd_pkg::div10(minute_ff);
      trem_d   = mbsd_pkg::div10(trem_ff);
      pct_d    = mbsd_pkg::div10(pct_ff[6:0]);
      cmd.idx  = idx_ff;
      cmd.kind = mbsd_pkg::CMD_WRITE;
      cmd.data = raw_ff;
      case (action_ff)
         mbsd_pkg::ACT_RAW: begin
            cmd.data = raw_ff;
         end
         mbsd_pkg::ACT_TIME: begin
            cmd.data = {mbsd_pkg::glyph(minute_d.units), mbsd_pkg::glyph(minute_d.tens),
                        mbsd_pkg::glyph(hour_d.units) | mbsd_pkg::SegColon,
                        mbsd_pkg::glyph(hour_d.tens)};
         end
         mbsd_pkg::ACT_TEMP: begin
            cmd.data = {mbsd_pkg::glyph(trem_d.units), mbsd_pkg::SegDegree,
                        mbsd_pkg::glyph(trem_d.tens), mbsd_pkg::glyph(hund_ff)};
         end
         mbsd_pkg::ACT_PERCENT: begin
            if (pct_ff > 8'(mbsd_pkg::TwoDigitMax)) begin
               cmd.data = {mbsd_pkg::SegLowerO, mbsd_pkg::SegDegree,
                           mbsd_pkg::glyph(4'd1), mbsd_pkg::SegH};
            end else begin
               cmd.data = {mbsd_pkg::SegLowerO, mbsd_pkg::SegDegree,
                           mbsd_pkg::glyph(pct_d.units), mbsd_pkg::glyph(pct_d.tens)};
            end
         end
         mbsd_pkg::ACT_SELECT: begin
            cmd.kind = mbsd_pkg::CMD_SELECT;
         end
         mbsd_pkg::ACT_NEXT: begin
            cmd.kind = mbsd_pkg::CMD_NEXT;
         end
         default: begin
            cmd.kind = mbsd_pkg::CMD_NOP;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/mbsd_back.sv =====
// Back end: holds the buffers, the active index and the count, and executes commands.
`default_nettype none

module mbsd_back #(
   parameter int MAX_BUFFERS = mbsd_pkg::MaxBuffers
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write,
   input  wire logic [mbsd_pkg::CountWidth-1:0]     csr_data,
   input  wire logic                                cmd_valid,
   output logic                                     cmd_pop,
   input  wire mbsd_pkg::cmd_type                   cmd,
   input  wire logic                                res_ready,
   output logic                                     res_push,
   output mbsd_pkg::result_type                     res
);

   localparam int IdxW = (MAX_BUFFERS > 1) ? $clog2(MAX_BUFFERS) : 1;
   localparam logic [mbsd_pkg::IndexWidth-1:0] MaxCount = 8'(MAX_BUFFERS);

   logic [mbsd_pkg::SegWidth-1:0]     bufs_ff [MAX_BUFFERS];
   logic [IdxW-1:0]                   active_ff, active_in;
   logic [mbsd_pkg::CountWidth-1:0]   count_ff;

   logic [mbsd_pkg::IndexWidth-1:0]   eff_count;
   logic [IdxW:0]                     next_raw;
   logic [mbsd_pkg::IndexWidth-1:0]   next_idx;
   logic [mbsd_pkg::IndexWidth-1:0]   tgt;
   logic                              fire;
   logic                              do_write;

   assign fire     = cmd_valid && res_ready;
   assign cmd_pop  = fire;
   assign res_push = fire;

   always_comb begin
      eff_count = ({4'd0, count_ff} > MaxCount) ? MaxCount : {4'd0, count_ff};
      next_raw  = {1'b0, active_ff} + (IdxW + 1)'(1);
      next_idx  = (8'(next_raw) == eff_count) ? 8'd0 : 8'(next_raw);
      tgt       = (cmd.kind == mbsd_pkg::CMD_NEXT) ? next_idx : cmd.idx;
   end

   always_comb begin
      res.status  = 1'b0;
      res.refresh = 1'b0;
      active_in   = active_ff;
      do_write    = 1'b0;
      case (cmd.kind)
         mbsd_pkg::CMD_WRITE: begin
            if (tgt >= eff_count) begin
               res.status = 1'b1;
            end else begin
               do_write    = fire;
               res.refresh = (tgt[IdxW-1:0] == active_ff);
            end
         end
         mbsd_pkg::CMD_SELECT, mbsd_pkg::CMD_NEXT: begin
            if (tgt >= eff_count) begin
               res.status = 1'b1;
            end else if (tgt[IdxW-1:0] != active_ff) begin
               res.refresh = 1'b1;
               if (fire) begin
                  active_in = tgt[IdxW-1:0];
               end
            end
         end
         default: begin
            res.status = 1'b0;
         end
      endcase
      // The shown word is the active buffer after this command has taken effect.
      if (cmd.kind == mbsd_pkg::CMD_WRITE && res.refresh) begin
         res.segments = cmd.data;
      end else begin
         res.segments = bufs_ff[active_in];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
         count_ff  <= mbsd_pkg::CountReset;
         for (int i = 0; i < MAX_BUFFERS; i++) begin
            bufs_ff[i] <= '0;
         end
      end else begin
         active_ff <= active_in;
         if (csr_write) begin
            count_ff <= csr_data;
         end
         if (do_write) begin
            bufs_ff[tgt[IdxW-1:0]] <= cmd.data;
         end
      end
   end

endmodule

`default_nettype wire
